@@ src/assert_macros.svh @@
// Assertion helpers for the sample encoder RTL.
// Both forms are clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every enabled edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/rse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Widths and codeword constants of the zero-run sample encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int WORD_BITS = 16;
  localparam int BUF_BITS  = 31;
  localparam int CNT_W     = 5;
  localparam int LZ_W      = 4;
  localparam int CODE_W    = 5;
  localparam int LEN_W     = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BUF_BITS-1:0]  bitbuf_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // empty window: one-bit code 0; otherwise five-bit code RUN_BASE + zeros
  localparam logic [CODE_W-1:0] CODE_EMPTY    = 5'd0;
  localparam logic [CODE_W-1:0] CODE_RUN_BASE = 5'd16;
  localparam logic [LEN_W-1:0]  LEN_EMPTY     = 3'd1;
  localparam logic [LEN_W-1:0]  LEN_RUN       = 3'd5;

  // zigzag map of a wrapped 16-bit difference
  function automatic word_t zigzag(input word_t d);
    return {d[WORD_BITS-2:0], 1'b0} ^ {WORD_BITS{d[WORD_BITS-1]}};
  endfunction

endpackage

@@ src/rake_sample_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rake_sample_encoder
// Delta + zigzag + zero-run coder for signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample per word, tdata = sample, tlast = final sample of block.
//   out_*  : one codeword per word, tdata = {code_length, code},
//            tlast = last codeword caused by a block's final sample.
//   cfg_*  : write of dc_offset, taken whenever valid is high; write only
//            while the encoder is idle.
// Throughput:
//   Its codewords follow one per cycle while out_tready stays high, 1 to 31
//   codewords per sample. They come from the single window shifter and
//   leading-one encoder, used once per codeword. in_tready is high only
//   between samples, so a new sample is not taken before the last is coded.
// Reset:
//   rst_n low clears the bit buffer, the previous sample and dc_offset, sets
//   the first-sample flag; no output word is pending afterwards.
// Stall:
//   A codeword sits in the output register until taken; while one waits and
//   out_tready is low the coder holds and no new codeword is produced.
// ----------------------------------------------------------------------------
module rake_sample_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] code, [7:5] code_length
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] dc_offset
);
  import rse_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic {S_IDLE, S_CODE} state_t;

  state_t  state_r, state_nxt;
  word_t   dc_r, dc_nxt;
  word_t   prev_r, prev_nxt;
  logic    first_r, first_nxt;
  logic    last_r, last_nxt;
  bitbuf_t buf_r, buf_nxt;
  cnt_t    cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              eob_r, eob_nxt;

  logic                          in_acc;
  word_t                         diff;
  logic [BUF_BITS+WORD_BITS-1:0] shift_src;
  logic [BUF_BITS+WORD_BITS-1:0] shifted;
  word_t                         window;
  logic [LZ_W-1:0]               lz;
  cnt_t                          drop;
  cnt_t                          cnt_new;
  bitbuf_t                       keep_mask;
  logic                          emit;
  logic                          out_free;
  logic                          done;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign diff = in_tdata - (first_r ? dc_r : prev_r);

  // shared window extractor: bits cnt-1 downward, zero padded on the right
  assign shift_src = {buf_r, {WORD_BITS{1'b0}}};
  assign shifted   = shift_src >> cnt_r;
  assign window    = shifted[WORD_BITS-1:0];

  always_comb begin
    lz = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (window[i]) lz = LZ_W'(WORD_BITS - 1 - i);
    end
  end

  assign drop      = (window == '0) ? CNT_W'(WORD_BITS) : CNT_W'(lz) + CNT_W'(1);
  assign cnt_new   = (drop >= cnt_r) ? '0 : cnt_r - drop;
  assign keep_mask = (BUF_BITS'(1) << cnt_new) - BUF_BITS'(1);

  // a window is coded while a full word waits, or any bit on a block's tail
  assign emit = (state_r == S_CODE) && out_free;
  assign done = !((cnt_new >= CNT_W'(WORD_BITS)) || (last_r && (cnt_new != '0)));

  always_comb begin
    state_nxt     = state_r;
    dc_nxt        = dc_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    code_nxt      = code_r;
    len_nxt       = len_r;
    eob_nxt       = eob_r;

    if (cfg_valid) dc_nxt = cfg_data;

    if (in_acc) begin
      buf_nxt   = {buf_r[BUF_BITS-WORD_BITS-1:0], zigzag(diff)};
      cnt_nxt   = cnt_r + CNT_W'(WORD_BITS);
      last_nxt  = in_tlast;
      prev_nxt  = in_tlast ? '0 : in_tdata;
      first_nxt = in_tlast;
      state_nxt = S_CODE;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (window == '0) begin
        code_nxt = CODE_EMPTY;
        len_nxt  = LEN_EMPTY;
      end else begin
        code_nxt = CODE_RUN_BASE + CODE_W'(lz);
        len_nxt  = LEN_RUN;
      end
      eob_nxt = last_r && done;
      cnt_nxt = cnt_new;
      buf_nxt = buf_r & keep_mask;
      if (done) state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_r        <= '0;
      prev_r      <= '0;
      first_r     <= 1'b1;
      last_r      <= 1'b0;
      buf_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      code_r      <= '0;
      len_r       <= '0;
      eob_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dc_r        <= dc_nxt;
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      code_r      <= code_nxt;
      len_r       <= len_nxt;
      eob_r       <= eob_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {len_r, code_r};
  assign out_tlast  = eob_r;

  // a sample always yields a codeword, so the coder is busy right after accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready)
  // between samples fewer than a full word waits in the buffer
  `ASSERT_ALWAYS(a_idle_partial, clk, rst_n,
                 !in_tready || (cnt_r < CNT_W'(WORD_BITS)))
  // length and code agree on every word sent
  `ASSERT_ALWAYS(a_code_len, clk, rst_n,
                 !out_tvalid || (len_r == LEN_EMPTY && code_r == CODE_EMPTY) ||
                 (len_r == LEN_RUN && code_r[CODE_W-1]))
  // end of a block leaves the buffer empty
  `ASSERT_NEXT(a_eob_empty, clk, rst_n, emit && last_r && done, cnt_r == '0)

endmodule

@@ test/tb_rake_sample_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rake_sample_encoder
// Self-checking bench for the zero-run sample encoder. Samples are streamed
// in directed and random blocks under several dc_offset settings. A local
// delta/zigzag/zero-run predictor builds the expected codewords, and each
// output word is checked field by field against them in order. Both stream
// sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_rake_sample_encoder;
  import rse_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_WAIT     = 5;

  typedef struct {
    word_t smp;
    logic  lst;
  } sample_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              eob;
  } codeword_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  sample_t   sample_q[$];
  codeword_t codeword_q[$];

  // predictor state
  word_t          dc_shadow  = '0;
  word_t          prev_smp   = '0;
  logic           first_blk  = 1'b1;
  logic [30:0]    bits       = '0;
  int             nbits      = 0;

  int        cycles     = 0;
  int        mismatches = 0;
  int        in_wait    = 0;
  int        out_wait   = 0;
  logic      in_hold;
  bit        in_quiet   = 1'b0;
  bit        out_quiet  = 1'b0;
  word_t     walk       = '0;
  codeword_t want;

  rake_sample_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] sample
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [4:0] code, [7:5] code_length
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // [15:0] dc_offset
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // code one 16-bit window, queue the codeword, return bits consumed
  function automatic int code_window(input word_t win);
    codeword_t cw;
    int        z;
    cw.eob = 1'b0;
    if (win == '0) begin
      cw.code = CODE_EMPTY;
      cw.len  = LEN_EMPTY;
      codeword_q.push_back(cw);
      return WORD_BITS;
    end
    z = 0;
    while (z < 15 && win[15 - z] == 1'b0) z++;
    cw.code = CODE_RUN_BASE + CODE_W'(z);
    cw.len  = LEN_RUN;
    codeword_q.push_back(cw);
    return z + 1;
  endfunction

  task automatic predict_codes(input word_t smp, input logic lst);
    word_t diff;
    word_t zz;
    word_t win;
    int    drop;
    diff = smp - (first_blk ? dc_shadow : prev_smp);
    // zigzag: 2d for d >= 0, -2d-1 = ~(2d) for d < 0
    zz = diff[15] ? ~(diff << 1) : (diff << 1);
    bits = {bits[14:0], zz};
    nbits += WORD_BITS;
    while (nbits >= WORD_BITS) begin
      win = word_t'(bits >> (nbits - WORD_BITS));
      drop = code_window(win);
      nbits -= drop;
      bits &= (31'd1 << nbits) - 31'd1;
    end
    if (lst) begin
      // tail flush: pad the leftover bits with zeros on the right
      while (nbits > 0) begin
        win = word_t'(bits << (WORD_BITS - nbits));
        drop = code_window(win);
        nbits = (drop >= nbits) ? 0 : nbits - drop;
        bits &= (31'd1 << nbits) - 31'd1;
      end
      codeword_q[codeword_q.size() - 1].eob = 1'b1;
      prev_smp  = '0;
      first_blk = 1'b1;
      bits      = '0;
      nbits     = 0;
    end else begin
      prev_smp  = smp;
      first_blk = 1'b0;
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_codes(in_tdata, in_tlast);
        void'(sample_q.pop_front());
        in_wait = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        in_hold = 1'b0;
      end else begin
        in_hold = in_tvalid;
      end
      if (!in_hold) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= sample_q[0].smp;
          in_tlast  <= sample_q[0].lst;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // codeword monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (codeword_q.size() == 0) begin
          flag_mismatch($sformatf("word %h / last %b with nothing pending", out_tdata,
                                  out_tlast));
        end else begin
          want = codeword_q.pop_front();
          if (out_tdata[4:0] !== want.code)
            flag_mismatch($sformatf("code %0d, want %0d", out_tdata[4:0], want.code));
          if (out_tdata[7:5] !== want.len)
            flag_mismatch($sformatf("code_length %0d, want %0d", out_tdata[7:5], want.len));
          if (out_tlast !== want.eob)
            flag_mismatch($sformatf("end_of_block %b, want %b", out_tlast, want.eob));
        end
        out_wait = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_item(input word_t s, input logic l);
    sample_t it;
    it.smp = s;
    it.lst = l;
    sample_q.push_back(it);
  endtask

  function automatic word_t next_sample();
    int    pick;
    word_t step;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      step = word_t'($urandom_range(0, 1 << $urandom_range(0, 12)));
      walk = $urandom_range(0, 1) ? walk + step : walk - step;
    end else if (pick == 5) begin
      case ($urandom_range(0, 3))
        0: walk = 16'h8000;
        1: walk = 16'h7FFF;
        2: walk = 16'h0000;
        default: walk = 16'hFFFF;
      endcase
    end else if (pick > 5) begin
      walk = word_t'($urandom());
    end
    // pick == 4 repeats the previous value: zero difference
    return walk;
  endfunction

  // mostly whole blocks closed by last, with an occasional early last
  task automatic push_random(input int n, input int maxlen);
    int   blk_left;
    logic lst;
    blk_left = 0;
    for (int i = 0; i < n; i++) begin
      if (blk_left == 0) blk_left = $urandom_range(1, maxlen);
      blk_left--;
      lst = (blk_left == 0);
      if ($urandom_range(0, 19) == 0) begin
        lst = 1'b1;
        blk_left = 0;
      end
      push_item(next_sample(), lst);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || codeword_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic new_setting(input word_t dc, input bit iq, input bit oq);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dc;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    dc_shadow = dc;
    in_quiet  = iq;
    out_quiet = oq;
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // dc_offset at its reset value
    push_item(16'h0000, 1'b0);  // empty windows
    push_item(16'h0000, 1'b0);
    push_item(16'h0001, 1'b0);
    push_item(16'h7FFF, 1'b0);
    push_item(16'h8000, 1'b0);  // difference wraps to +1
    push_item(16'h7FFF, 1'b0);  // difference wraps to -1
    push_item(16'hFFFF, 1'b0);  // most negative difference
    push_item(16'h7FFF, 1'b0);
    push_item(16'h7FFE, 1'b0);
    push_item(16'h7FFE, 1'b1);  // zero difference, then flush
    push_item(16'h4000, 1'b1);  // single-sample block, padded tail
    push_item(16'h8000, 1'b1);
    push_item(16'h0000, 1'b0);
    push_item(16'h0001, 1'b0);
    push_item(16'h0001, 1'b0);
    push_item(16'h0001, 1'b1);

    new_setting(16'h8000, 1'b1, 1'b0);
    push_item(16'h7FFF, 1'b1);
    push_item(16'h8000, 1'b1);
    push_random(50, 8);

    new_setting(16'h7FFF, 1'b0, 1'b1);
    push_item(16'h8000, 1'b1);
    push_item(16'h7FFF, 1'b1);
    push_random(50, 12);

    new_setting(word_t'($urandom()), 1'b0, 1'b0);
    push_random(60, 40);

    new_setting(16'h0000, 1'b1, 1'b1);
    push_random(50, 4);

    new_setting(word_t'($urandom()), 1'b0, 1'b0);
    push_random(40, 10);

    wait_drained();
    if (mismatches == 0 && codeword_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
